// ===== sv/gaussian_particle_weight_2d_macros.svh =====
// ----------------------------------------------------------------------------
// Gaussian particle weight assertion macros
// Shared concurrent assertion forms for the weight unit.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_PARTICLE_WEIGHT_2D_MACROS_SVH
`define GAUSSIAN_PARTICLE_WEIGHT_2D_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GPW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gaussian particle weight: assertion failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define GPW_ASSERT_DLY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("gaussian particle weight: timing assertion failed");

`endif

// ===== sv/gpw_pkg.sv =====
// ----------------------------------------------------------------------------
// Gaussian particle weight package
// Shared widths, codes, queue word types and the exp table generator.
// ----------------------------------------------------------------------------
package gpw_pkg;

    // Field and datapath widths.
    localparam int POS_W     = 16;
    localparam int ERR_W     = 17;
    localparam int MAG_W     = 16;
    localparam int SQ_W      = 32;
    localparam int INV_W     = 24;
    localparam int PROD_W    = 56;
    localparam int SUM_W     = 57;
    localparam int A16_W     = 20;
    localparam int T16_W     = 21;
    localparam int SHIFT_W   = 5;
    localparam int ENTRY_W   = 17;
    localparam int WEIGHT_W  = 16;
    localparam int CFG_ADDR_W = 1;

    // Arithmetic constants.
    localparam logic [16:0] LOG2E_Q16    = 17'd94548;
    localparam logic [63:0] LN2_Q30      = 64'd744261118;
    localparam int          ARG_LIMIT_INT = 12;
    localparam int          SERIES_TERMS  = 24;

    // Queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_INV_VAR_X = 1'b0,
        CFG_INV_VAR_Y = 1'b1
    } t_cfg_reg;

    // One queued word: squared errors and the zero-error class bit.
    typedef struct packed {
        logic [SQ_W-1:0] sq_x;
        logic [SQ_W-1:0] sq_y;
        logic            zero;
    } t_q_word;

    // Queue status seen by the top level.
    typedef struct packed {
        logic empty;
        logic full;
        logic near_full;
    } t_q_status;

    // Truncating division of a series term by its index.
    function automatic logic [63:0] div_term(input logic [63:0] x, input logic [4:0] k);
        logic [63:0] q;
        unique case (k)
            5'd1:    q = x / 1;
            5'd2:    q = x / 2;
            5'd3:    q = x / 3;
            5'd4:    q = x / 4;
            5'd5:    q = x / 5;
            5'd6:    q = x / 6;
            5'd7:    q = x / 7;
            5'd8:    q = x / 8;
            5'd9:    q = x / 9;
            5'd10:   q = x / 10;
            5'd11:   q = x / 11;
            5'd12:   q = x / 12;
            5'd13:   q = x / 13;
            5'd14:   q = x / 14;
            5'd15:   q = x / 15;
            5'd16:   q = x / 16;
            5'd17:   q = x / 17;
            5'd18:   q = x / 18;
            5'd19:   q = x / 19;
            5'd20:   q = x / 20;
            5'd21:   q = x / 21;
            5'd22:   q = x / 22;
            5'd23:   q = x / 23;
            5'd24:   q = x / 24;
            default: q = x;
        endcase
        return q;
    endfunction

    // exp(-y) in Q.16 for y given in Q.30, by an alternating Taylor series.
    function automatic logic [ENTRY_W-1:0] frac_entry(input logic [63:0] arg_q30);
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic [63:0]        rounded;
        term = 64'd1 << 30;
        acc  = signed'(term);
        for (int k = 1; k <= SERIES_TERMS; k++) begin
            term = div_term((term * arg_q30) >> 30, 5'(k));
            if (k[0]) begin
                acc = acc - signed'(term);
            end else begin
                acc = acc + signed'(term);
            end
        end
        if (acc < 0) begin
            acc = '0;
        end
        rounded = (unsigned'(acc) + 64'd8192) >> 14;
        return rounded[ENTRY_W-1:0];
    endfunction

endpackage

// ===== sv/gpw_front.sv =====
// ----------------------------------------------------------------------------
// Gaussian particle weight front end
// Takes a position word, forms the axis errors, squares them and marks words
// whose errors are both zero before handing them to the queue.
// ----------------------------------------------------------------------------
module gpw_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic signed [gpw_pkg::POS_W-1:0]    i_pred_x,
    input  logic signed [gpw_pkg::POS_W-1:0]    i_pred_y,
    input  logic signed [gpw_pkg::POS_W-1:0]    i_obs_x,
    input  logic signed [gpw_pkg::POS_W-1:0]    i_obs_y,
    output logic                                o_push,
    output gpw_pkg::t_q_word                    o_word
);

    logic signed [gpw_pkg::ERR_W-1:0] w_ex;
    logic signed [gpw_pkg::ERR_W-1:0] w_ey;
    logic [gpw_pkg::ERR_W-1:0]        w_abs_x;
    logic [gpw_pkg::ERR_W-1:0]        w_abs_y;

    logic                             r_s1_vld;
    logic [gpw_pkg::MAG_W-1:0]        r_mag_x;
    logic [gpw_pkg::MAG_W-1:0]        r_mag_y;
    logic                             r_s2_vld;
    gpw_pkg::t_q_word                 r_word;

    // Sign-extended errors and their magnitudes.
    assign w_ex    = {i_pred_x[gpw_pkg::POS_W-1], i_pred_x}
                   - {i_obs_x[gpw_pkg::POS_W-1], i_obs_x};
    assign w_ey    = {i_pred_y[gpw_pkg::POS_W-1], i_pred_y}
                   - {i_obs_y[gpw_pkg::POS_W-1], i_obs_y};
    assign w_abs_x = w_ex[gpw_pkg::ERR_W-1] ? unsigned'(-w_ex) : unsigned'(w_ex);
    assign w_abs_y = w_ey[gpw_pkg::ERR_W-1] ? unsigned'(-w_ey) : unsigned'(w_ey);

    // Valid bits of the two front stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_accept;
            r_s2_vld <= r_s1_vld;
        end
    end

    // Stage one holds the magnitudes, stage two the squares and the class bit.
    always_ff @(posedge i_clk) begin
        r_mag_x     <= w_abs_x[gpw_pkg::MAG_W-1:0];
        r_mag_y     <= w_abs_y[gpw_pkg::MAG_W-1:0];
        r_word.sq_x <= gpw_pkg::SQ_W'(r_mag_x) * gpw_pkg::SQ_W'(r_mag_x);
        r_word.sq_y <= gpw_pkg::SQ_W'(r_mag_y) * gpw_pkg::SQ_W'(r_mag_y);
        r_word.zero <= (r_mag_x == '0) && (r_mag_y == '0);
    end

    assign o_push = r_s2_vld;
    assign o_word = r_word;

endmodule

// ===== sv/gpw_queue.sv =====
// ----------------------------------------------------------------------------
// Gaussian particle weight queue
// Small first-in first-out buffer that decouples the front from the back.
// ----------------------------------------------------------------------------
module gpw_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  gpw_pkg::t_q_word     i_word,
    input  logic                 i_pop,
    output gpw_pkg::t_q_word     o_word,
    output gpw_pkg::t_q_status   o_stat
);

    gpw_pkg::t_q_word                r_mem [gpw_pkg::Q_DEPTH];
    logic [gpw_pkg::Q_PTR_W-1:0]     r_wr_ptr;
    logic [gpw_pkg::Q_PTR_W-1:0]     r_rd_ptr;
    logic [gpw_pkg::Q_CNT_W-1:0]     r_count;
    logic                            w_do_push;
    logic                            w_do_pop;

    assign w_do_push = i_push && !o_stat.full;
    assign w_do_pop  = i_pop && !o_stat.empty;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    assign o_word           = r_mem[r_rd_ptr];
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == gpw_pkg::Q_CNT_W'(gpw_pkg::Q_DEPTH));
    assign o_stat.near_full = (r_count >= gpw_pkg::Q_CNT_W'(gpw_pkg::Q_DEPTH - 2));

endmodule

// ===== sv/gpw_back.sv =====
// ----------------------------------------------------------------------------
// Gaussian particle weight back end
// Scales the squared errors, reduces the exponent base two, looks up the
// fractional power and shifts it into the Q0.16 weight.
// ----------------------------------------------------------------------------
module gpw_back #(
    parameter int POS_FRAC_BITS     = 8,
    parameter int EXP_TABLE_ENTRIES = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_vld,
    input  gpw_pkg::t_q_word                     i_word,
    input  logic [gpw_pkg::INV_W-1:0]            i_inv_var_x,
    input  logic [gpw_pkg::INV_W-1:0]            i_inv_var_y,
    output logic                                 o_valid,
    output logic [gpw_pkg::WEIGHT_W-1:0]         o_weight
);

    localparam int IDX_W = $clog2(EXP_TABLE_ENTRIES + 1);
    localparam int FE_W  = 25;
    localparam int T_W   = 37;
    localparam logic [gpw_pkg::SUM_W-1:0] ARG_LIMIT =
        gpw_pkg::SUM_W'(gpw_pkg::ARG_LIMIT_INT) << (16 + 2 * POS_FRAC_BITS);

    // Constant table of 2^(-i/EXP_TABLE_ENTRIES), i = 0..EXP_TABLE_ENTRIES.
    logic [gpw_pkg::ENTRY_W-1:0] w_lut [EXP_TABLE_ENTRIES + 1];

    for (genvar gi = 0; gi <= EXP_TABLE_ENTRIES; gi++) begin : g_lut
        localparam logic [63:0] ArgQ30 =
            (64'(gi) * gpw_pkg::LN2_Q30 + 64'(EXP_TABLE_ENTRIES / 2)) / EXP_TABLE_ENTRIES;
        assign w_lut[gi] = gpw_pkg::frac_entry(ArgQ30);
    end

    // Stage valid bits.
    logic                              r_b1_vld, r_b2_vld, r_b3_vld, r_b4_vld, r_b5_vld;
    // Stage payloads.
    logic [gpw_pkg::PROD_W-1:0]        r_b1_px, r_b1_py;
    logic                              r_b1_zero;
    logic [gpw_pkg::A16_W-1:0]         r_b2_a16;
    logic                              r_b2_far, r_b2_zero;
    logic [gpw_pkg::T16_W-1:0]         r_b3_t16;
    logic                              r_b3_far, r_b3_zero;
    logic [IDX_W-1:0]                  r_b4_idx;
    logic [gpw_pkg::SHIFT_W-1:0]       r_b4_n;
    logic                              r_b4_far, r_b4_zero;
    logic [gpw_pkg::ENTRY_W-1:0]       r_b5_e;
    logic [gpw_pkg::SHIFT_W-1:0]       r_b5_n;
    logic                              r_b5_far, r_b5_zero;
    logic                              r_valid;
    logic [gpw_pkg::WEIGHT_W-1:0]      r_weight;

    logic [gpw_pkg::SUM_W-1:0]         w_sum;
    logic [T_W-1:0]                    w_t;
    logic [FE_W-1:0]                   w_fe;
    logic [gpw_pkg::ENTRY_W:0]         w_half;
    logic [gpw_pkg::ENTRY_W:0]         w_shift;
    logic [gpw_pkg::WEIGHT_W-1:0]      n_weight;

    // Argument sum, base-2 conversion and table index.
    assign w_sum = gpw_pkg::SUM_W'(r_b1_px) + gpw_pkg::SUM_W'(r_b1_py);
    assign w_t   = T_W'(r_b2_a16) * T_W'(gpw_pkg::LOG2E_Q16) + T_W'(32768);
    assign w_fe  = FE_W'(r_b3_t16[15:0]) * FE_W'(EXP_TABLE_ENTRIES) + FE_W'(32768);

    // Rounded right shift of the table entry by the integer part.
    assign w_half  = (r_b5_n == '0) ? '0
                   : ((gpw_pkg::ENTRY_W + 1)'(1) << (r_b5_n - 1'b1));
    assign w_shift = ((gpw_pkg::ENTRY_W + 1)'(r_b5_e) + w_half) >> r_b5_n;

    // Final selection and saturation.
    always_comb begin
        priority if (r_b5_far) begin
            n_weight = '0;
        end else if (r_b5_zero || (w_shift > (gpw_pkg::ENTRY_W + 1)'(16'hFFFF))) begin
            n_weight = '1;
        end else begin
            n_weight = w_shift[gpw_pkg::WEIGHT_W-1:0];
        end
    end

    // Valid pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
            r_b2_vld <= 1'b0;
            r_b3_vld <= 1'b0;
            r_b4_vld <= 1'b0;
            r_b5_vld <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_b1_vld <= i_vld;
            r_b2_vld <= r_b1_vld;
            r_b3_vld <= r_b2_vld;
            r_b4_vld <= r_b3_vld;
            r_b5_vld <= r_b4_vld;
            r_valid  <= r_b5_vld;
        end
    end

    // Data pipeline.
    always_ff @(posedge i_clk) begin
        r_b1_px   <= gpw_pkg::PROD_W'(i_word.sq_x) * gpw_pkg::PROD_W'(i_inv_var_x);
        r_b1_py   <= gpw_pkg::PROD_W'(i_word.sq_y) * gpw_pkg::PROD_W'(i_inv_var_y);
        r_b1_zero <= i_word.zero;

        r_b2_a16  <= w_sum[2 * POS_FRAC_BITS +: gpw_pkg::A16_W];
        r_b2_far  <= (w_sum >= ARG_LIMIT);
        r_b2_zero <= r_b1_zero;

        r_b3_t16  <= w_t[16 +: gpw_pkg::T16_W];
        r_b3_far  <= r_b2_far;
        r_b3_zero <= r_b2_zero;

        r_b4_idx  <= w_fe[16 +: IDX_W];
        r_b4_n    <= r_b3_t16[16 +: gpw_pkg::SHIFT_W];
        r_b4_far  <= r_b3_far;
        r_b4_zero <= r_b3_zero;

        r_b5_e    <= w_lut[r_b4_idx];
        r_b5_n    <= r_b4_n;
        r_b5_far  <= r_b4_far;
        r_b5_zero <= r_b4_zero;

        r_weight  <= n_weight;
    end

    assign o_valid  = r_valid;
    assign o_weight = r_weight;

endmodule

// ===== sv/gaussian_particle_weight_2d.sv =====
// ----------------------------------------------------------------------------
// Gaussian particle weight unit, two-dimensional
// Weight = exp(-(ex^2 * inv_var_x + ey^2 * inv_var_y)) in unsigned Q0.16.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a predicted and an observed position; the word is taken
//   at each rising edge where start is high and busy is low. The front forms
//   and squares the errors, a four-word queue hands them to the back, which
//   scales, converts to base two, looks up the fraction and shifts.
//   o_valid is high for one cycle with o_weight once the word has passed the
//   front, the queue and the back. One word per cycle is sustained while busy
//   is low, and each stage takes a new word every cycle.
//   Results cannot be held off; the back never stalls, so busy stays low in
//   normal operation.
//   The inverse variances are written through i_cfg_we / i_cfg_addr /
//   i_cfg_wdata (index 0 for x, 1 for y) while no word is in flight.
//   Reset clears the pipeline and the queue, sets both inverse variances to
//   1.0 and holds busy high until the first cycle after reset.
// ----------------------------------------------------------------------------
`include "gaussian_particle_weight_2d_macros.svh"

module gaussian_particle_weight_2d #(
    parameter int POS_FRAC_BITS     = 8,
    parameter int EXP_TABLE_ENTRIES = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [gpw_pkg::POS_W-1:0]     i_pred_x,
    input  logic signed [gpw_pkg::POS_W-1:0]     i_pred_y,
    input  logic signed [gpw_pkg::POS_W-1:0]     i_obs_x,
    input  logic signed [gpw_pkg::POS_W-1:0]     i_obs_y,
    input  logic                                 i_cfg_we,
    input  logic [gpw_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [gpw_pkg::INV_W-1:0]            i_cfg_wdata,
    output logic                                 o_valid,
    output logic [gpw_pkg::WEIGHT_W-1:0]         o_weight
);

    localparam int OUT_LAT = 9;

    logic                          r_busy;
    logic [gpw_pkg::INV_W-1:0]     r_inv_var_x;
    logic [gpw_pkg::INV_W-1:0]     r_inv_var_y;
    logic                          w_accept;
    logic                          w_push;
    logic                          w_pop;
    gpw_pkg::t_q_word              w_front_word;
    gpw_pkg::t_q_word              w_back_word;
    gpw_pkg::t_q_status            w_q_stat;

    assign w_accept = start && !r_busy;
    assign w_pop    = !w_q_stat.empty;
    assign busy     = r_busy;

    // Configuration registers and the busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_var_x <= gpw_pkg::INV_W'(65536);
            r_inv_var_y <= gpw_pkg::INV_W'(65536);
            r_busy      <= 1'b1;
        end else begin
            r_busy <= w_q_stat.near_full;
            if (i_cfg_we) begin
                unique case (gpw_pkg::t_cfg_reg'(i_cfg_addr))
                    gpw_pkg::CFG_INV_VAR_X: r_inv_var_x <= i_cfg_wdata;
                    gpw_pkg::CFG_INV_VAR_Y: r_inv_var_y <= i_cfg_wdata;
                    default:                r_inv_var_x <= r_inv_var_x;
                endcase
            end
        end
    end

    // Front: errors and squares.
    gpw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_pred_x (i_pred_x),
        .i_pred_y (i_pred_y),
        .i_obs_x  (i_obs_x),
        .i_obs_y  (i_obs_y),
        .o_push   (w_push),
        .o_word   (w_front_word)
    );

    // Queue between front and back.
    gpw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_word  (w_front_word),
        .i_pop   (w_pop),
        .o_word  (w_back_word),
        .o_stat  (w_q_stat)
    );

    // Back: scaling, exponent and output register.
    gpw_back #(
        .POS_FRAC_BITS     (POS_FRAC_BITS),
        .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (w_pop),
        .i_word      (w_back_word),
        .i_inv_var_x (r_inv_var_x),
        .i_inv_var_y (r_inv_var_y),
        .o_valid     (o_valid),
        .o_weight    (o_weight)
    );

    // Every accepted word yields exactly one result after the fixed latency.
    `GPW_ASSERT_DLY(a_result_latency, i_clk, i_rst_n, w_accept, OUT_LAT, o_valid)
    `GPW_ASSERT_IMP(a_result_has_source, i_clk, i_rst_n, o_valid, $past(w_accept, OUT_LAT))
    // The back drains every cycle, so the queue never overflows.
    `GPW_ASSERT_IMP(a_queue_no_overflow, i_clk, i_rst_n, w_push, !w_q_stat.full)

endmodule
